/* hdl/oriented_box_grid_dispatch_region_unit_assert.svh */
// Assertion macros shared by the grid dispatch region RTL.
// Included by modules that check their own pipeline control; needs no other file.
`ifndef ORIENTED_BOX_GRID_DISPATCH_REGION_UNIT_ASSERT_SVH
`define ORIENTED_BOX_GRID_DISPATCH_REGION_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OBBG_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("obbg assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define OBBG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("obbg assertion failed");

`endif

/* hdl/obbg_pkg.sv */
// Package for the oriented box grid dispatch region unit: widths, register indexes
// and the stage control struct. Depends on nothing.
package obbg_pkg;

    localparam int COORD_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int OUT_WIDTH     = 16;
    localparam int CFG_INDEX_WIDTH = 3;

    localparam logic [OUT_WIDTH-1:0] OUT_MAX = '1;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GRID_CORNER_X     = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GRID_CORNER_Y     = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GRID_CORNER_Z     = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CELL_RECIPROCAL_X = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CELL_RECIPROCAL_Y = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CELL_RECIPROCAL_Z = 3'd5;

    typedef struct packed {
        logic s1_en;
        logic s2_en;
        logic s3_en;
        logic s4_en;
    } stage_ctl_t;

endpackage

/* hdl/obbg_channels.sv */
// Handshake channels of the grid dispatch region unit: box input, cell range
// output and configuration write. Depends on obbg_pkg.
interface obbg_box_if #(
    parameter int COORD_WIDTH = obbg_pkg::COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic signed [COORD_WIDTH-1:0] center_z;
    logic signed [COORD_WIDTH-1:0] forward_half_x;
    logic signed [COORD_WIDTH-1:0] forward_half_y;
    logic signed [COORD_WIDTH-1:0] forward_half_z;
    logic signed [COORD_WIDTH-1:0] up_half_x;
    logic signed [COORD_WIDTH-1:0] up_half_y;
    logic signed [COORD_WIDTH-1:0] up_half_z;
    logic signed [COORD_WIDTH-1:0] right_half_x;
    logic signed [COORD_WIDTH-1:0] right_half_y;
    logic signed [COORD_WIDTH-1:0] right_half_z;

    modport source (
        output valid, center_x, center_y, center_z,
               forward_half_x, forward_half_y, forward_half_z,
               up_half_x, up_half_y, up_half_z,
               right_half_x, right_half_y, right_half_z,
        input  ready
    );
    modport sink (
        input  valid, center_x, center_y, center_z,
               forward_half_x, forward_half_y, forward_half_z,
               up_half_x, up_half_y, up_half_z,
               right_half_x, right_half_y, right_half_z,
        output ready
    );
endinterface

interface obbg_range_if;
    logic                               valid;
    logic                               ready;
    logic [obbg_pkg::OUT_WIDTH-1:0] first_cell_x;
    logic [obbg_pkg::OUT_WIDTH-1:0] first_cell_y;
    logic [obbg_pkg::OUT_WIDTH-1:0] first_cell_z;
    logic [obbg_pkg::OUT_WIDTH-1:0] cell_count_x;
    logic [obbg_pkg::OUT_WIDTH-1:0] cell_count_y;
    logic [obbg_pkg::OUT_WIDTH-1:0] cell_count_z;

    modport source (
        output valid, first_cell_x, first_cell_y, first_cell_z,
               cell_count_x, cell_count_y, cell_count_z,
        input  ready
    );
    modport sink (
        input  valid, first_cell_x, first_cell_y, first_cell_z,
               cell_count_x, cell_count_y, cell_count_z,
        output ready
    );
endinterface

interface obbg_cfg_if #(
    parameter int COORD_WIDTH = obbg_pkg::COORD_WIDTH
);
    logic                                     valid;
    logic                                     ready;
    logic [obbg_pkg::CFG_INDEX_WIDTH-1:0] index;
    logic [COORD_WIDTH-1:0]                   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* hdl/obbg_axis.sv */
// One axis of the cell range pipeline: abs values, box minimum and extent,
// split multiply by the reciprocal, truncation and saturation. Depends on obbg_pkg.
module obbg_axis #(
    parameter int COORD_WIDTH   = obbg_pkg::COORD_WIDTH,
    parameter int FRACTION_BITS = obbg_pkg::FRACTION_BITS
) (
    input  logic                                 clk,
    input  obbg_pkg::stage_ctl_t                 ctl,
    input  logic signed [COORD_WIDTH-1:0]        center,
    input  logic signed [COORD_WIDTH-1:0]        forward_half,
    input  logic signed [COORD_WIDTH-1:0]        up_half,
    input  logic signed [COORD_WIDTH-1:0]        right_half,
    input  logic signed [COORD_WIDTH-1:0]        grid_corner,
    input  logic [COORD_WIDTH-1:0]               cell_reciprocal,
    output logic [obbg_pkg::OUT_WIDTH-1:0]       first_cell,
    output logic [obbg_pkg::OUT_WIDTH-1:0]       cell_count
);

    localparam int CW     = COORD_WIDTH;
    localparam int AW     = CW + 2;
    localparam int SW     = CW + 3;
    localparam int LW     = (AW + 1) / 2;
    localparam int HW     = AW - LW;
    localparam int PW     = AW + CW;
    localparam int PSHIFT = 2 * FRACTION_BITS;
    localparam int OW     = obbg_pkg::OUT_WIDTH;
    localparam int QW     = OW + 1;

    localparam logic [QW-1:0] Q_FIRST_SAT = QW'(obbg_pkg::OUT_MAX) + QW'(2);
    localparam logic [QW-1:0] Q_COUNT_SAT = QW'(obbg_pkg::OUT_MAX) - QW'(1);

    logic signed [CW-1:0] center_reg;
    logic [CW-1:0]        abs_f_reg;
    logic [CW-1:0]        abs_u_reg;
    logic [CW-1:0]        abs_r_reg;
    logic [CW-1:0]        abs_f_next;
    logic [CW-1:0]        abs_u_next;
    logic [CW-1:0]        abs_r_next;

    logic [AW-1:0]        ext;
    logic signed [SW-1:0] adj;
    logic                 adj_pos;
    logic [AW-1:0]        adj_mag_reg;
    logic [AW-1:0]        adj_mag_next;
    logic [AW-1:0]        ext2_reg;
    logic [AW-1:0]        ext2_next;

    logic [LW+CW-1:0]     first_lo_reg;
    logic [HW+CW-1:0]     first_hi_reg;
    logic [LW+CW-1:0]     count_lo_reg;
    logic [HW+CW-1:0]     count_hi_reg;

    logic [PW-1:0]        first_prod;
    logic [PW-1:0]        count_prod;
    logic [PW-1:0]        first_q;
    logic [PW-1:0]        count_q;
    logic                 first_big;
    logic                 count_big;
    logic [QW-1:0]        first_qlo;
    logic [QW-1:0]        count_qlo;
    logic [OW-1:0]        first_cell_reg;
    logic [OW-1:0]        first_cell_next;
    logic [OW-1:0]        cell_count_reg;
    logic [OW-1:0]        cell_count_next;

    // Stage 1: magnitudes of the three half-axis components.
    assign abs_f_next = forward_half[CW-1] ? (~forward_half + 1'b1) : forward_half;
    assign abs_u_next = up_half[CW-1] ? (~up_half + 1'b1) : up_half;
    assign abs_r_next = right_half[CW-1] ? (~right_half + 1'b1) : right_half;

    // Stage 2: half extent, box minimum relative to the grid corner.
    assign ext = AW'(abs_f_reg) + AW'(abs_u_reg) + AW'(abs_r_reg);
    assign adj = SW'(center_reg) - $signed({1'b0, ext}) - SW'(grid_corner);
    assign adj_pos = !adj[SW-1] && (adj != '0);
    assign adj_mag_next = adj_pos ? adj[AW-1:0] : '0;
    assign ext2_next = {ext[AW-2:0], 1'b0};

    // Stage 4: recombine the partial products and saturate.
    assign first_prod = PW'(first_lo_reg) + (PW'(first_hi_reg) << LW);
    assign count_prod = PW'(count_lo_reg) + (PW'(count_hi_reg) << LW);
    assign first_q = first_prod >> PSHIFT;
    assign count_q = count_prod >> PSHIFT;
    assign first_big = |(first_q >> QW);
    assign count_big = |(count_q >> QW);
    assign first_qlo = first_q[QW-1:0];
    assign count_qlo = count_q[QW-1:0];

    always_comb
    begin
        if (!first_big && (first_qlo == '0))
        begin
            first_cell_next = '0;
        end
        else if (first_big || (first_qlo >= Q_FIRST_SAT))
        begin
            first_cell_next = obbg_pkg::OUT_MAX;
        end
        else
        begin
            first_cell_next = OW'(first_qlo - QW'(1));
        end

        if (count_big || (count_qlo >= Q_COUNT_SAT))
        begin
            cell_count_next = obbg_pkg::OUT_MAX;
        end
        else
        begin
            cell_count_next = OW'(count_qlo + QW'(2));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.s1_en)
        begin
            center_reg <= center;
            abs_f_reg  <= abs_f_next;
            abs_u_reg  <= abs_u_next;
            abs_r_reg  <= abs_r_next;
        end
        if (ctl.s2_en)
        begin
            adj_mag_reg <= adj_mag_next;
            ext2_reg    <= ext2_next;
        end
        if (ctl.s3_en)
        begin
            first_lo_reg <= adj_mag_reg[LW-1:0] * cell_reciprocal;
            first_hi_reg <= adj_mag_reg[AW-1:LW] * cell_reciprocal;
            count_lo_reg <= ext2_reg[LW-1:0] * cell_reciprocal;
            count_hi_reg <= ext2_reg[AW-1:LW] * cell_reciprocal;
        end
        if (ctl.s4_en)
        begin
            first_cell_reg <= first_cell_next;
            cell_count_reg <= cell_count_next;
        end
    end

    assign first_cell = first_cell_reg;
    assign cell_count = cell_count_reg;

endmodule

/* hdl/oriented_box_grid_dispatch_region_unit.sv */
// An accepted box word becomes its cell range word after the magnitude, extent, multiply and saturate stages.
// One box word per cycle; each stage holds one word and stalls only when the stage after
// it is full and not advancing, or for the output stage when ranges.ready is low.
// Reset clears all stage valid bits and loads the grid corner with zero and the
// cell reciprocals with one; configuration writes are always accepted.
// Depends on obbg_pkg, obbg_channels, obbg_axis and the assertion macro header.
`include "oriented_box_grid_dispatch_region_unit_assert.svh"

module oriented_box_grid_dispatch_region_unit #(
    parameter int COORD_WIDTH   = obbg_pkg::COORD_WIDTH,
    parameter int FRACTION_BITS = obbg_pkg::FRACTION_BITS
) (
    input  logic           clk,
    input  logic           rst_n,
    obbg_box_if.sink       boxes,
    obbg_range_if.source   ranges,
    obbg_cfg_if.sink       cfg
);

    localparam logic [COORD_WIDTH-1:0] RECIP_ONE = COORD_WIDTH'(1) << FRACTION_BITS;

    obbg_pkg::stage_ctl_t ctl;
    logic [3:0] valid_reg;
    logic [3:0] valid_next;

    logic signed [COORD_WIDTH-1:0] grid_corner_x_reg;
    logic signed [COORD_WIDTH-1:0] grid_corner_y_reg;
    logic signed [COORD_WIDTH-1:0] grid_corner_z_reg;
    logic [COORD_WIDTH-1:0]        cell_reciprocal_x_reg;
    logic [COORD_WIDTH-1:0]        cell_reciprocal_y_reg;
    logic [COORD_WIDTH-1:0]        cell_reciprocal_z_reg;

    assign ctl.s4_en = !valid_reg[3] || ranges.ready;
    assign ctl.s3_en = !valid_reg[2] || ctl.s4_en;
    assign ctl.s2_en = !valid_reg[1] || ctl.s3_en;
    assign ctl.s1_en = !valid_reg[0] || ctl.s2_en;

    assign boxes.ready  = ctl.s1_en;
    assign ranges.valid = valid_reg[3];
    assign cfg.ready    = 1'b1;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.s1_en)
        begin
            valid_next[0] = boxes.valid;
        end
        if (ctl.s2_en)
        begin
            valid_next[1] = valid_reg[0];
        end
        if (ctl.s3_en)
        begin
            valid_next[2] = valid_reg[1];
        end
        if (ctl.s4_en)
        begin
            valid_next[3] = valid_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg             <= '0;
            grid_corner_x_reg     <= '0;
            grid_corner_y_reg     <= '0;
            grid_corner_z_reg     <= '0;
            cell_reciprocal_x_reg <= RECIP_ONE;
            cell_reciprocal_y_reg <= RECIP_ONE;
            cell_reciprocal_z_reg <= RECIP_ONE;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    obbg_pkg::REG_GRID_CORNER_X:     grid_corner_x_reg <= cfg.data;
                    obbg_pkg::REG_GRID_CORNER_Y:     grid_corner_y_reg <= cfg.data;
                    obbg_pkg::REG_GRID_CORNER_Z:     grid_corner_z_reg <= cfg.data;
                    obbg_pkg::REG_CELL_RECIPROCAL_X: cell_reciprocal_x_reg <= cfg.data;
                    obbg_pkg::REG_CELL_RECIPROCAL_Y: cell_reciprocal_y_reg <= cfg.data;
                    obbg_pkg::REG_CELL_RECIPROCAL_Z: cell_reciprocal_z_reg <= cfg.data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    obbg_axis #(
        .COORD_WIDTH   (COORD_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_axis_x (
        .clk             (clk),
        .ctl             (ctl),
        .center          (boxes.center_x),
        .forward_half    (boxes.forward_half_x),
        .up_half         (boxes.up_half_x),
        .right_half      (boxes.right_half_x),
        .grid_corner     (grid_corner_x_reg),
        .cell_reciprocal (cell_reciprocal_x_reg),
        .first_cell      (ranges.first_cell_x),
        .cell_count      (ranges.cell_count_x)
    );

    obbg_axis #(
        .COORD_WIDTH   (COORD_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_axis_y (
        .clk             (clk),
        .ctl             (ctl),
        .center          (boxes.center_y),
        .forward_half    (boxes.forward_half_y),
        .up_half         (boxes.up_half_y),
        .right_half      (boxes.right_half_y),
        .grid_corner     (grid_corner_y_reg),
        .cell_reciprocal (cell_reciprocal_y_reg),
        .first_cell      (ranges.first_cell_y),
        .cell_count      (ranges.cell_count_y)
    );

    obbg_axis #(
        .COORD_WIDTH   (COORD_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_axis_z (
        .clk             (clk),
        .ctl             (ctl),
        .center          (boxes.center_z),
        .forward_half    (boxes.forward_half_z),
        .up_half         (boxes.up_half_z),
        .right_half      (boxes.right_half_z),
        .grid_corner     (grid_corner_z_reg),
        .cell_reciprocal (cell_reciprocal_z_reg),
        .first_cell      (ranges.first_cell_z),
        .cell_count      (ranges.cell_count_z)
    );

    // A cell count is never below two.
    `OBBG_ASSERT_SAME(a_count_min, clk, rst_n, ranges.valid, (ranges.cell_count_x >= 16'd2) && (ranges.cell_count_y >= 16'd2) && (ranges.cell_count_z >= 16'd2))
    // An empty first stage always takes a word.
    `OBBG_ASSERT_SAME(a_empty_ready, clk, rst_n, !valid_reg[0], boxes.ready)
    // A word in stage three moves into the output stage when it advances.
    `OBBG_ASSERT_NEXT(a_s3_to_s4, clk, rst_n, valid_reg[2] && ctl.s4_en, valid_reg[3])
    // A blocked word in stage one stays there.
    `OBBG_ASSERT_NEXT(a_s1_hold, clk, rst_n, valid_reg[0] && !ctl.s2_en, valid_reg[0])

endmodule
